[src/npm_pkg.sv]
// package for normalized_power_metrics
// constants, widths and result type; no dependencies
package npm_pkg;
  localparam int WindowLen = 30;
  localparam int MaxSeconds = 65535;
  localparam int TssDivisor = 36;
  localparam int JoulesPerKj = 1000;
  localparam int PosW = $clog2(WindowLen);
  localparam logic [10:0] ThresholdReset = 11'd200;

  // window mean in Q.4: (total * 16) / WindowLen by reciprocal multiply
  localparam int MeanShift = 24;
  localparam longint unsigned MeanRecip =
    ((64'd1 << (MeanShift + 4)) + 64'(WindowLen) - 64'd1) / 64'(WindowLen);

  // energy / 1000 by reciprocal multiply
  localparam int KjShift = 37;
  localparam longint unsigned KjRecip =
    ((64'd1 << KjShift) + 64'(JoulesPerKj) - 64'd1) / 64'(JoulesPerKj);

  typedef struct packed {
    logic [10:0] normalized_power;
    logic [10:0] average_power;
    logic [17:0] work_kilojoules;
    logic [15:0] total_seconds;
    logic [15:0] intensity_milli;
    logic [15:0] variability_milli;
    logic [15:0] stress_score;
    logic        short_workout;
    logic        count_overflow;
  } result_t;
endpackage

[src/npm_if.sv]
// channel interfaces for normalized_power_metrics
// depends on npm_pkg
interface npm_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] power_watts;
  logic        last_sample;
  modport source (output valid, power_watts, last_sample, input ready);
  modport sink (input valid, power_watts, last_sample, output ready);
endinterface

interface npm_out_if;
  logic             valid;
  logic             ready;
  npm_pkg::result_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface npm_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/npm_divider.sv]
// shared restoring divider, one quotient bit per cycle, 64-bit operands
// depends on nothing
module npm_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dsr;
  logic [6:0]  count;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
        count <= 7'd0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[src/normalized_power_metrics.sv]
// Normalized power, intensity and stress score over one workout. One power sample per
// transfer, taken only in S_IDLE; the 30-sample window lives in a one-port synchronous
// memory, read in S_READ and written back in S_UPD. Once the window is full, a sample
// also passes S_MEAN, S_SQ, S_FOURTH and S_ACC (window mean, square, fourth power and
// saturating add). On the sample marked last the block runs its finish sequence through
// one shared 64-bit serial divider (up to five divides plus a 16-step root search; a
// single divide for a short workout) and presents one result, then clears its totals.
// The window memory needs no clear: entries are read only once written in the current
// workout. threshold_power is written on the config channel.
module normalized_power_metrics (
  input logic       clk,
  input logic       rst,
  npm_in_if.sink    in_ch,
  npm_out_if.source out_ch,
  npm_cfg_if.sink   cfg
);
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_READ   = 14'b00000000000010,
    S_UPD    = 14'b00000000000100,
    S_MEAN   = 14'b00000000001000,
    S_SQ     = 14'b00000000010000,
    S_FOURTH = 14'b00000000100000,
    S_ACC    = 14'b00000001000000,
    S_FIN    = 14'b00000010000000,
    S_DIV    = 14'b00000100000000,
    S_ROOT   = 14'b00001000000000,
    S_ROOTM  = 14'b00010000000000,
    S_PREP   = 14'b00100000000000,
    S_MUL    = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state;
  logic [10:0] window_mem [npm_pkg::WindowLen];
  logic [10:0] old_sample;
  logic [npm_pkg::PosW-1:0] pos;
  logic [10:0] threshold_power;
  logic [10:0] sample;
  logic        last;
  logic [15:0] window_total;
  logic [63:0] fourth_power_total;
  logic [27:0] energy_total;
  logic [15:0] seconds_seen;
  logic        overflow_seen;
  logic [15:0] mean;
  logic [31:0] sq;
  logic [63:0] fourth;
  logic [2:0]  step;
  logic [63:0] mean4;
  logic [15:0] r_lo;
  logic [15:0] r_hi;
  logic [15:0] r_mid;
  logic [31:0] mid_sq;
  logic [14:0] r;
  logic [63:0] tmp;
  logic        div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic        div_done;
  logic [63:0] div_q;
  logic        shortw;
  npm_pkg::result_t res;
  logic [64:0] acc_sum;
  logic [40:0] mean_prod;
  logic [55:0] kj_prod;

  npm_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data = res;
  assign acc_sum = {1'b0, fourth_power_total} + {1'b0, fourth};
  assign r_mid = 16'((17'(r_lo) + 17'(r_hi) + 17'd1) >> 1);
  assign mean_prod = 41'(window_total) * 41'(npm_pkg::MeanRecip);
  assign kj_prod = 56'(energy_total) * 56'(npm_pkg::KjRecip);

  always_ff @(posedge clk) begin
    if (state == S_UPD) window_mem[pos] <= sample;
    old_sample <= window_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_power <= npm_pkg::ThresholdReset;
    end else if (cfg.valid) begin
      threshold_power <= cfg.data;
    end
  end

  function automatic logic [15:0] sat16(input logic [63:0] v);
    return (v > 64'd65535) ? 16'hffff : v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_total <= '0;
      fourth_power_total <= '0;
      energy_total <= '0;
      seconds_seen <= '0;
      overflow_seen <= 1'b0;
      pos <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            sample <= in_ch.power_watts;
            last <= in_ch.last_sample;
            if (seconds_seen == 16'(npm_pkg::MaxSeconds)) begin
              overflow_seen <= 1'b1;
              state <= in_ch.last_sample ? S_FIN : S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          window_total <= window_total
                          - ((seconds_seen < 16'(npm_pkg::WindowLen)) ? 16'd0
                                                                        : 16'(old_sample))
                          + 16'(sample);
          pos <= (pos == npm_pkg::PosW'(npm_pkg::WindowLen - 1)) ? '0
                 : pos + npm_pkg::PosW'(1);
          energy_total <= energy_total + 28'(sample);
          seconds_seen <= seconds_seen + 16'd1;
          state <= (seconds_seen + 16'd1 >= 16'(npm_pkg::WindowLen)) ? S_MEAN
                   : (last ? S_FIN : S_IDLE);
        end
        S_MEAN: begin
          mean <= mean_prod[npm_pkg::MeanShift +: 16];
          state <= S_SQ;
        end
        S_SQ: begin
          sq <= mean * mean;
          state <= S_FOURTH;
        end
        S_FOURTH: begin
          fourth <= sq * sq;
          state <= S_ACC;
        end
        S_ACC: begin
          fourth_power_total <= acc_sum[64] ? '1 : acc_sum[63:0];
          state <= last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          step <= 3'd0;
          res <= {11'd0, 11'd0, kj_prod[npm_pkg::KjShift +: 18], seconds_seen,
                  16'd0, 16'd0, 16'd0, 1'b0, overflow_seen};
          shortw <= (seconds_seen < 16'(npm_pkg::WindowLen));
          div_a <= 64'(energy_total);
          div_b <= (seconds_seen == 16'd0) ? 64'd1 : 64'(seconds_seen);
          div_start <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            unique case (step)
              3'd0: begin
                res.average_power <= (seconds_seen == 16'd0) ? 11'd0
                                     : ((div_q > 64'd2047) ? 11'd2047 : div_q[10:0]);
                if (shortw) begin
                  res.short_workout <= 1'b1;
                  state <= S_OUT;
                end else begin
                  div_a <= fourth_power_total;
                  div_b <= 64'(seconds_seen - 16'(npm_pkg::WindowLen - 1));
                  div_start <= 1'b1;
                  step <= 3'd2;
                end
              end
              3'd2: begin
                mean4 <= div_q;
                r_lo <= '0;
                r_hi <= 16'hffff;
                state <= S_ROOT;
              end
              default: state <= S_PREP;
            endcase
          end
        end
        S_ROOT: begin
          if (r_lo == r_hi) begin
            r <= (r_lo > 16'd32767) ? 15'h7fff : r_lo[14:0];
            step <= 3'd3;
            state <= S_PREP;
          end else begin
            mid_sq <= r_mid * r_mid;
            state <= S_ROOTM;
          end
        end
        S_ROOTM: begin
          if (64'(mid_sq) * 64'(mid_sq) <= mean4) begin
            r_lo <= r_mid;
          end else begin
            r_hi <= r_mid - 16'd1;
          end
          state <= S_ROOT;
        end
        S_PREP: begin
          unique case (step)
            3'd3: begin
              res.normalized_power <= r[14:4];
              tmp <= 64'(r) * 64'd1000;
              div_b <= 64'(threshold_power) * 64'd16;
              state <= S_MUL;
            end
            3'd4: begin
              tmp <= 64'(r) * 64'(r);
              div_b <= 64'(threshold_power) * 64'(threshold_power);
              state <= S_MUL;
            end
            3'd5: begin
              tmp <= 64'(r) * 64'd1000;
              div_b <= 64'(energy_total) * 64'd16;
              state <= S_MUL;
            end
            default: state <= S_OUT;
          endcase
        end
        S_MUL: begin
          unique case (step)
            3'd3: begin
              if (threshold_power == 11'd0) begin
                res.short_workout <= 1'b1;
                step <= 3'd5;
                state <= S_PREP;
              end else begin
                div_a <= tmp;
                div_start <= 1'b1;
                state <= S_DIV;
              end
            end
            3'd4: begin
              div_a <= 64'(tmp[31:0]) * 64'(seconds_seen);
              div_b <= div_b * 64'(256 * npm_pkg::TssDivisor);
              div_start <= 1'b1;
              state <= S_DIV;
            end
            default: begin
              if (energy_total == 28'd0) begin
                res.short_workout <= 1'b1;
                state <= S_OUT;
              end else begin
                div_a <= 64'(tmp[31:0]) * 64'(seconds_seen);
                div_start <= 1'b1;
                state <= S_DIV;
              end
            end
          endcase
        end
        S_OUT: begin
          if (out_ch.ready) begin
            window_total <= '0;
            fourth_power_total <= '0;
            energy_total <= '0;
            seconds_seen <= '0;
            overflow_seen <= 1'b0;
            pos <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && div_done && step >= 3'd3) begin
        unique case (step)
          3'd3: begin
            res.intensity_milli <= sat16(div_q);
            step <= 3'd4;
          end
          3'd4: begin
            res.stress_score <= sat16(div_q);
            step <= 3'd5;
          end
          default: begin
            res.variability_milli <= sat16(div_q);
            step <= 3'd6;
          end
        endcase
      end
    end
  end
endmodule

[src/npm_checker.sv]
// port-level assertions for normalized_power_metrics
// depends on npm_pkg and the top level's interfaces
module npm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] secs,
  input logic        shortw
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during result");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && secs < 16'(npm_pkg::WindowLen) |-> shortw) else $error("short flag");
  a_secs_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(secs)) else $error("payload changed");
endmodule

bind normalized_power_metrics npm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .secs(out_ch.data.total_seconds), .shortw(out_ch.data.short_workout)
);

[bench/normalized_power_metrics_test.sv]
// testbench for normalized_power_metrics: directed workouts from a table, then random
// workouts under several threshold settings, every result checked against its table entry or a predictor
// depends on npm_pkg, the channel interfaces in npm_if.sv and the block itself
`timescale 1ns / 100ps

module normalized_power_metrics_test;
  localparam int CycleLimit = 4000000;
  localparam int DrainCycles = 40;
  localparam int FinishGap = 20;
  localparam longint unsigned AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [10:0]      power;
    int               repeats;
    bit               fixed;
    npm_pkg::result_t want;
  } workout_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  npm_in_if  in_ch ();
  npm_out_if out_ch ();
  npm_cfg_if cfg ();

  normalized_power_metrics DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [10:0]     ftp;
  logic [10:0]     win_buf [npm_pkg::WindowLen];
  logic [15:0]     win_sum;
  longint unsigned quad_sum;
  logic [27:0]     joules;
  logic [15:0]     sec_count;
  bit              ovf_seen;

  npm_pkg::result_t expected_results [$];
  int      errors = 0;
  int      results_seen = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_used = 1'b0;
  int      hold_left = 0;

  function automatic longint unsigned sat16(longint unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic longint unsigned int_root4(longint unsigned m);
    longint unsigned lo, hi, mid, sq;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      sq = mid * mid;
      if (sq * sq <= m) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic clear_workout();
    for (int i = 0; i < npm_pkg::WindowLen; i++) win_buf[i] = '0;
    win_sum = '0;
    quad_sum = 0;
    joules = '0;
    sec_count = '0;
    ovf_seen = 1'b0;
  endtask

  // advance the predictor by one sample; has_result set on the last sample
  task automatic predict_sample(input logic [10:0] p, input bit last,
                                output bit has_result, output npm_pkg::result_t r);
    int pos;
    longint unsigned mean, f, secs, energy, windows, root, avg, tp;
    pos = 0;
    has_result = 1'b0;
    r = '0;
    if (sec_count >= npm_pkg::MaxSeconds) begin
      ovf_seen = 1'b1;
    end else begin
      pos = sec_count % npm_pkg::WindowLen;
      win_sum = win_sum - win_buf[pos] + p;
      win_buf[pos] = p;
      joules = joules + p;
      sec_count = sec_count + 1;
      if (sec_count >= npm_pkg::WindowLen) begin
        mean = (longint'(win_sum) * 16) / npm_pkg::WindowLen;
        f = mean * mean * mean * mean;
        if (quad_sum > AllOnes - f) quad_sum = AllOnes;
        else quad_sum = quad_sum + f;
      end
    end
    if (last) begin
      has_result = 1'b1;
      secs = sec_count;
      energy = joules;
      tp = ftp;
      avg = (secs != 0) ? energy / secs : 0;
      if (avg > 2047) avg = 2047;
      r.average_power = avg[10:0];
      r.work_kilojoules = 18'(energy / 1000);
      r.total_seconds = secs[15:0];
      r.count_overflow = ovf_seen;
      if (secs < npm_pkg::WindowLen) begin
        r.short_workout = 1'b1;
      end else begin
        windows = secs - npm_pkg::WindowLen + 1;
        root = int_root4(quad_sum / windows);
        if (root > 32767) root = 32767;
        r.normalized_power = 11'(root >> 4);
        if (tp == 0) begin
          r.short_workout = 1'b1;
        end else begin
          r.intensity_milli = 16'(sat16((root * 1000) / (16 * tp)));
          r.stress_score = 16'(sat16((secs * root * root) /
                                     (256 * tp * tp * npm_pkg::TssDivisor)));
        end
        if (energy == 0) r.short_workout = 1'b1;
        else r.variability_milli = 16'(sat16((root * 1000 * secs) / (16 * energy)));
      end
      clear_workout();
    end
  endtask

  task automatic report(input string field, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", field, got, want,
             results_seen);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    npm_pkg::result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        report("unexpected result transfer", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.normalized_power !== want.normalized_power)
          report("normalized_power", got.normalized_power, want.normalized_power);
        if (got.average_power !== want.average_power)
          report("average_power", got.average_power, want.average_power);
        if (got.work_kilojoules !== want.work_kilojoules)
          report("work_kilojoules", got.work_kilojoules, want.work_kilojoules);
        if (got.total_seconds !== want.total_seconds)
          report("total_seconds", got.total_seconds, want.total_seconds);
        if (got.intensity_milli !== want.intensity_milli)
          report("intensity_milli", got.intensity_milli, want.intensity_milli);
        if (got.variability_milli !== want.variability_milli)
          report("variability_milli", got.variability_milli, want.variability_milli);
        if (got.stress_score !== want.stress_score)
          report("stress_score", got.stress_score, want.stress_score);
        if (got.short_workout !== want.short_workout)
          report("short_workout", got.short_workout, want.short_workout);
        if (got.count_overflow !== want.count_overflow)
          report("count_overflow", got.count_overflow, want.count_overflow);
      end
      results_seen++;
    end
  end

  // result side ready, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [10:0] p, input bit last, input bit fixed,
                             input npm_pkg::result_t want);
    bit has_result;
    npm_pkg::result_t r;
    while (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.power_watts <= p;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    predict_sample(p, last, has_result, r);
    if (has_result) expected_results.push_back(fixed ? want : r);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (FinishGap) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [10:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    ftp = value;
  endtask

  function automatic logic [10:0] random_power();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 11'd0;
    if (sel < 20) return 11'd2047;
    if (sel < 60) return 11'($urandom_range(2047));
    return 11'($urandom_range(400, 100));
  endfunction

  task automatic random_workout();
    int sel, len;
    npm_pkg::result_t none;
    none = '0;
    sel = $urandom_range(99);
    if (sel < 70) len = $urandom_range(60, 30);
    else if (sel < 90) len = $urandom_range(29, 1);
    else len = $urandom_range(200, 61);
    for (int i = 1; i <= len; i++) send_sample(random_power(), i == len, 1'b0, none);
  endtask

  workout_row_t     rows [$];
  logic [10:0]      settings [$];
  npm_pkg::result_t w;
  npm_pkg::result_t none;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.power_watts = '0;
    in_ch.last_sample = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    none = '0;
    ftp = npm_pkg::ThresholdReset;
    clear_workout();

    // single zero sample
    w = '0; w.total_seconds = 1; w.short_workout = 1'b1;
    rows.push_back('{11'd0, 1, 1'b1, w});
    // single full-scale sample
    w = '0; w.average_power = 2047; w.work_kilojoules = 2; w.total_seconds = 1;
    w.short_workout = 1'b1;
    rows.push_back('{11'd2047, 1, 1'b1, w});
    // short workout
    w = '0; w.average_power = 1000; w.work_kilojoules = 5; w.total_seconds = 5;
    w.short_workout = 1'b1;
    rows.push_back('{11'd1000, 5, 1'b1, w});
    // one full window with zero energy
    w = '0; w.total_seconds = 30; w.short_workout = 1'b1;
    rows.push_back('{11'd0, 30, 1'b1, w});
    // one full window at full scale
    w = '0; w.normalized_power = 2047; w.average_power = 2047; w.work_kilojoules = 61;
    w.total_seconds = 30; w.intensity_milli = 10235; w.variability_milli = 1000;
    w.stress_score = 87;
    rows.push_back('{11'd2047, 30, 1'b1, w});
    rows.push_back('{11'd100, 40, 1'b0, none});
    rows.push_back('{11'd1500, 31, 1'b0, none});
    rows.push_back('{11'd1, 29, 1'b0, none});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k])
      for (int i = 1; i <= rows[k].repeats; i++)
        send_sample(rows[k].power, i == rows[k].repeats, rows[k].fixed, rows[k].want);
    go_idle();

    settings = '{11'd1, 11'd2047, 11'd0, 11'd200, 11'd150, 11'd300};
    for (int s = 0; s < 6; s++) settings.push_back(11'($urandom_range(2047, 1)));
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      calm = (s == 3);
      if (s == 4) hold_req = 1'b1;
      repeat (3) random_workout();
      go_idle();
    end
    calm = 1'b0;
    while (items_sent < 950) begin
      if ($urandom_range(99) < 10) begin
        go_idle();
        write_threshold(11'($urandom_range(2047, 1)));
      end
      random_workout();
    end
    go_idle();
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[files.f]
src/npm_pkg.sv
src/npm_if.sv
src/npm_divider.sv
src/normalized_power_metrics.sv
src/npm_checker.sv
bench/normalized_power_metrics_test.sv
